// ----- hdl/barometric_sensor_compensation_core_macros.svh -----
// Assertion macros for the barometric compensation core
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsc check failed");
// next-cycle implication
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsc check failed");
`else
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/bsc_pkg.sv -----
// Shared constants, types and scale tables for the barometric compensation core
`default_nettype none
package bsc_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int RAW_W      = 24;
  localparam int FIX_SHIFT  = FRAC_BITS - 19;   // raw * 2^F / 524288
  localparam int FIX_W      = RAW_W + FIX_SHIFT;
  localparam int CFG_W      = 48;
  localparam int TEMP_OUT_W = 24;
  localparam int PRES_OUT_W = 32;

  typedef enum logic [1:0] {
    CFG_COEF_LOW  = 2'd0,
    CFG_COEF_MID  = 2'd1,
    CFG_COEF_HIGH = 2'd2,
    CFG_TEMP_OSR  = 2'd3
  } cfg_idx_t;

  // scale = div * 2^(24 - shift); divisor part of the scale factor
  function automatic logic [7:0] osr_div(input logic [2:0] code);
    logic [7:0] d;
    case (code)
      3'd0:    d = 8'd1;
      3'd1:    d = 8'd3;
      3'd2:    d = 8'd7;
      3'd3:    d = 8'd15;
      3'd4:    d = 8'd31;
      3'd5:    d = 8'd63;
      3'd6:    d = 8'd127;
      3'd7:    d = 8'd255;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // ceil(2^32 / div), exact quotient for dividends below 2^24
  function automatic logic [32:0] osr_recip(input logic [2:0] code);
    logic [32:0] m;
    case (code)
      3'd0:    m = 33'h1_0000_0000;
      3'd1:    m = 33'h0_5555_5556;
      3'd2:    m = 33'h0_2492_4925;
      3'd3:    m = 33'h0_1111_1112;
      3'd4:    m = 33'h0_0842_1085;
      3'd5:    m = 33'h0_0410_4105;
      3'd6:    m = 33'h0_0204_0811;
      3'd7:    m = 33'h0_0101_0102;
      default: m = 33'h1_0000_0000;
    endcase
    return m;
  endfunction

  // power-of-two part of 2^F / scale
  function automatic logic [3:0] osr_shift(input logic [2:0] code);
    return code[2] ? 4'd11 : 4'd5;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bsc_fmul.sv -----
// Pipelined signed fixed-point multiply, trunc(a * b / 2^FRAC), four stages
`default_nettype none
module bsc_fmul
  import bsc_pkg::*;
#(
  parameter int WA   = 29,
  parameter int WB   = 46,
  parameter int FRAC = FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WA-1:0]      a,
  input  logic signed [WB-1:0]      b,
  output logic signed [WA+WB-FRAC:0] p
);

  localparam int LO = WB / 2;
  localparam int HI = WB - LO;
  localparam int WP = WA + WB;
  localparam int WQ = WP - FRAC + 1;

  logic [WA-1:0]      ua_r;
  logic [WB-1:0]      ub_r;
  logic               neg1_r, neg2_r, neg3_r;
  logic [WA+LO-1:0]   pl_r;
  logic [WA+HI-1:0]   ph_r;
  logic [WQ-2:0]      q_r;
  logic signed [WQ-1:0] p_r;
  logic [WP-1:0]      sum;

  // partial products recombined, magnitude truncated
  assign sum = (WP'(ph_r) << LO) + WP'(pl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= a[WA-1] ? WA'(-a) : WA'(a);
      ub_r   <= b[WB-1] ? WB'(-b) : WB'(b);
      neg1_r <= a[WA-1] ^ b[WB-1];
      pl_r   <= (WA+LO)'(ua_r) * (WA+LO)'(ub_r[LO-1:0]);
      ph_r   <= (WA+HI)'(ua_r) * (WA+HI)'(ub_r[WB-1:LO]);
      neg2_r <= neg1_r;
      q_r    <= sum[WP-1:FRAC];
      neg3_r <= neg2_r;
      p_r    <= neg3_r ? -$signed(WQ'(q_r)) : $signed(WQ'(q_r));
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- hdl/barometric_sensor_compensation_core.sv -----
// Throughput: one request per cycle; the whole pipeline advances unless the output
// register holds a result that is stalled, so in_stall follows out_stall at once.
// Reset (synchronous, rst_n low): valid bits cleared, coefficient and OSR registers zero.
// Pipeline payload registers carry no reset.
`default_nettype none
`include "barometric_sensor_compensation_core_macros.svh"
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [RAW_W-1:0]      in_temp_raw,
  input  logic signed [RAW_W-1:0]      in_pres_raw,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [TEMP_OUT_W-1:0] out_temperature_centi,
  output logic signed [PRES_OUT_W-1:0] out_pressure_pa,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] coef_low_r, coef_mid_r, coef_high_r;
  logic [2:0]       osr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_low_r  <= '0;
      coef_mid_r  <= '0;
      coef_high_r <= '0;
      osr_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_LOW:  coef_low_r  <= cfg_data;
        CFG_COEF_MID:  coef_mid_r  <= cfg_data;
        CFG_COEF_HIGH: coef_high_r <= cfg_data;
        CFG_TEMP_OSR:  osr_r       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // coefficient unpack
  logic signed [11:0] c0_raw, c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign c0_raw = $signed(coef_low_r[47:36]);
  assign c0     = (c0_raw + $signed({11'd0, c0_raw[11]})) >>> 1;   // halve toward zero
  assign c1     = $signed(coef_low_r[35:24]);
  assign c00    = $signed(coef_low_r[23:4]);
  assign c10    = $signed({coef_low_r[3:0], coef_mid_r[47:32]});
  assign c01    = $signed(coef_mid_r[31:16]);
  assign c11    = $signed(coef_mid_r[15:0]);
  assign c20    = $signed(coef_high_r[47:32]);
  assign c21    = $signed(coef_high_r[31:16]);
  assign c30    = $signed(coef_high_r[15:0]);

  logic [7:0]  osr_d;
  logic [32:0] osr_m;
  logic [3:0]  osr_sh;
  assign osr_d  = osr_div(osr_r);
  assign osr_m  = osr_recip(osr_r);
  assign osr_sh = osr_shift(osr_r);

  // global pipeline advance
  logic en;
  logic out_valid_r;
  logic [12:1] v_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[11:1], in_valid};
      out_valid_r <= v_r[12];
    end
  end

  // ---------------- pressure path ----------------
  logic signed [FIX_W-1:0] t_in, p_in;
  assign t_in = $signed({in_temp_raw, FIX_SHIFT'(0)});
  assign p_in = $signed({in_pres_raw, FIX_SHIFT'(0)});

  logic signed [FIX_W-1:0] t1_r;
  logic signed [FIX_W-1:0] p_r [1:7];
  logic signed [44:0]      pc30_1_r, pc21_1_r, tc01_1_r;
  logic signed [45:0]      a2_r;
  logic signed [45:0]      d_r [2:5];
  logic signed [45:0]      k_r [2:9];
  logic signed [51:0]      pa6;
  logic signed [52:0]      b7_r;
  logic signed [58:0]      c11w;
  logic signed [34:0]      tp5;
  logic signed [57:0]      e9;
  logic signed [58:0]      ke10_r, ke11_r;
  logic signed [59:0]      tot12_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= t_in;
      p_r[1]   <= p_in;
      pc30_1_r <= 45'(p_in) * 45'(c30);
      pc21_1_r <= 45'(p_in) * 45'(c21);
      tc01_1_r <= 45'(t_in) * 45'(c01);
      a2_r     <= 46'(pc30_1_r) + (46'(c20) <<< FRAC_BITS);
      d_r[2]   <= 46'(pc21_1_r) + (46'(c11) <<< FRAC_BITS);
      k_r[2]   <= 46'(tc01_1_r) + (46'(c00) <<< FRAC_BITS);
      for (int i = 2; i <= 7; i++) p_r[i] <= p_r[i-1];
      for (int i = 3; i <= 5; i++) d_r[i] <= d_r[i-1];
      for (int i = 3; i <= 9; i++) k_r[i] <= k_r[i-1];
      b7_r     <= 53'(pa6) + (53'(c10) <<< FRAC_BITS);
      ke10_r   <= 59'(k_r[9]) + 59'(e9);
      ke11_r   <= ke10_r;
      tot12_r  <= 60'(ke11_r) + 60'(c11w);
    end
  end

  // t * p
  bsc_fmul #(.WA(FIX_W), .WB(FIX_W), .FRAC(FRAC_BITS)) u_fmul_tp (
    .clk(clk), .en(en), .a(t1_r), .b(p_r[1]), .p(tp5)
  );
  // p * (p*c30 + c20)
  bsc_fmul #(.WA(FIX_W), .WB(46), .FRAC(FRAC_BITS)) u_fmul_pa (
    .clk(clk), .en(en), .a(p_r[2]), .b(a2_r), .p(pa6)
  );
  // (t*p) * (p*c21 + c11)
  bsc_fmul #(.WA(35), .WB(46), .FRAC(FRAC_BITS)) u_fmul_e (
    .clk(clk), .en(en), .a(tp5), .b(d_r[5]), .p(e9)
  );
  // p * b
  bsc_fmul #(.WA(FIX_W), .WB(53), .FRAC(FRAC_BITS)) u_fmul_pb (
    .clk(clk), .en(en), .a(p_r[7]), .b(b7_r), .p(c11w)
  );

  // final scale toward zero and clamp
  logic signed [59:0] tot_bias;
  logic signed [35:0] pres_q;
  logic signed [PRES_OUT_W-1:0] pres_nxt;

  assign tot_bias = tot12_r + (tot12_r[59] ? 60'((64'd1 << FRAC_BITS) - 64'd1) : 60'd0);
  assign pres_q   = $signed(tot_bias[59:FRAC_BITS]);

  always_comb begin
    if (pres_q > 36'sh0_7FFF_FFFF)       pres_nxt = 32'sh7FFF_FFFF;
    else if (pres_q < -36'sh0_8000_0000) pres_nxt = 32'sh8000_0000;
    else                                 pres_nxt = pres_q[31:0];
  end

  // ---------------- temperature path ----------------
  logic [RAW_W-1:0]  tmag_r [1:3];
  logic              tneg_r [1:6];
  logic [RAW_W-1:0]  qa_r [2:5];
  logic [56:0]       qa_prod;
  logic [31:0]       qd3_r;
  logic [7:0]        ra4_r;
  logic [18:0]       rk;
  logic [51:0]       fr_prod;
  logic [10:0]       fr5_r;
  logic [34:0]       tsm6_r;
  logic signed [35:0] ts7_r;
  logic signed [47:0] c1ts8_r;
  logic signed [48:0] tfix9_r;
  logic signed [56:0] x100_10_r, x_bias;
  logic signed [32:0] tq11_r, tq12_r;
  logic signed [TEMP_OUT_W-1:0] temp_nxt;

  assign qa_prod = 57'(tmag_r[1]) * 57'(osr_m);
  assign rk      = 19'(ra4_r) << osr_sh;
  assign fr_prod = 52'(rk) * 52'(osr_m);
  assign x_bias  = x100_10_r + (x100_10_r[56] ? 57'((64'd1 << FRAC_BITS) - 64'd1) : 57'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      tmag_r[1] <= in_temp_raw[RAW_W-1] ? RAW_W'(-in_temp_raw) : RAW_W'(in_temp_raw);
      tneg_r[1] <= in_temp_raw[RAW_W-1];
      for (int i = 2; i <= 3; i++) tmag_r[i] <= tmag_r[i-1];
      for (int i = 2; i <= 6; i++) tneg_r[i] <= tneg_r[i-1];
      for (int i = 3; i <= 5; i++) qa_r[i]   <= qa_r[i-1];
      // integer quotient of |raw| / div
      qa_r[2]   <= qa_prod[55:32];
      qd3_r     <= 32'(qa_r[2]) * 32'(osr_d);
      ra4_r     <= 8'(tmag_r[3] - qd3_r[23:0]);
      // fractional part: floor(rem * 2^shift / div)
      fr5_r     <= fr_prod[42:32];
      tsm6_r    <= (35'(qa_r[5]) << osr_sh) + 35'(fr5_r);
      ts7_r     <= tneg_r[6] ? -$signed(36'(tsm6_r)) : $signed(36'(tsm6_r));
      c1ts8_r   <= 48'(c1) * 48'(ts7_r);
      tfix9_r   <= 49'(c1ts8_r) + (49'(c0) <<< FRAC_BITS);
      x100_10_r <= 57'(tfix9_r) * 57'sd100;
      tq11_r    <= $signed(x_bias[56:FRAC_BITS]);
      tq12_r    <= tq11_r;
    end
  end

  always_comb begin
    if (tq12_r > 33'sh0_007F_FFFF)       temp_nxt = 24'sh7F_FFFF;
    else if (tq12_r < -33'sh0_0080_0000) temp_nxt = 24'sh80_0000;
    else                                 temp_nxt = tq12_r[23:0];
  end

  // output register
  logic signed [TEMP_OUT_W-1:0] temp_out_r;
  logic signed [PRES_OUT_W-1:0] pres_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      temp_out_r <= temp_nxt;
      pres_out_r <= pres_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_out_r;
  assign out_pressure_pa       = pres_out_r;

  // checks
  `BSC_ASSERT_IMP(a_stall_back, clk, rst_n, out_valid_r && out_stall, in_stall)
  `BSC_ASSERT_NXT(a_deliver, clk, rst_n, v_r[12] && !in_stall, out_valid_r)
  `BSC_ASSERT_NXT(a_no_extra, clk, rst_n, !v_r[12] && !in_stall, !out_valid_r)

endmodule
`default_nettype wire
